// ===== hw/rtl/fpr_pkg.sv =====
// Package for the FIFO page replacement block: constants, register indexes
// and the small structs passed between the top level and the frame cells.
// No dependencies.
package fpr_pkg;

   // Elaboration defaults for the top-level parameters
   localparam int MAX_FRAMES_DEF = 8;
   localparam int PAGE_BITS_DEF  = 16;

   // Field widths fixed by the interface
   localparam int TIME_W  = 32;
   localparam int PERIOD_W = 16;
   localparam int LIMIT_W = 4;
   localparam int BITS_W  = 8;

   // Configuration channel
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_PERIOD   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES_IN_USE = 4'd1;

   // Register reset values
   localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST   = 16'd20;
   localparam logic [LIMIT_W-1:0]  FRAMES_IN_USE_RST = 4'd5;

   // Per-frame status flags held by a cell
   typedef struct packed {
      logic occ;
      logic r_bit;
      logic m_bit;
   } fpr_flags_type;

   // Per-cell control for one request beat
   typedef struct packed {
      logic step;   // a request is being processed this cycle
      logic tick;   // clock interrupt: clear R bits
      logic shift;  // eviction: take the neighbour's frame
      logic load;   // this cell receives the new page
      logic wr;     // write access
   } fpr_ctrl_type;

endpackage

// ===== hw/rtl/fpr_req_if.sv =====
// Request channel: page id, access time and read/write flag.
// Depends on fpr_pkg.
interface fpr_req_if #(
   parameter int PAGE_BITS = fpr_pkg::PAGE_BITS_DEF
);
   import fpr_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [PAGE_BITS-1:0] page_id;
   logic [TIME_W-1:0]    access_time;
   logic                 is_write;

   modport source (output valid, page_id, access_time, is_write, input ready);
   modport sink   (input valid, page_id, access_time, is_write, output ready);
endinterface

// ===== hw/rtl/fpr_rsp_if.sv =====
// Result channel: hit, eviction, tick and R/M bit snapshot per request.
// Depends on fpr_pkg.
interface fpr_rsp_if #(
   parameter int PAGE_BITS = fpr_pkg::PAGE_BITS_DEF
);
   import fpr_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic                 evicted_valid;
   logic [PAGE_BITS-1:0] evicted_page;
   logic                 write_back;
   logic                 tick_taken;
   logic [TIME_W-1:0]    tick_time;
   logic [BITS_W-1:0]    referenced_bits;
   logic [BITS_W-1:0]    modified_bits;

   modport source (output valid, hit, evicted_valid, evicted_page, write_back, tick_taken,
                   tick_time, referenced_bits, modified_bits, input ready);
   modport sink   (input valid, hit, evicted_valid, evicted_page, write_back, tick_taken,
                   tick_time, referenced_bits, modified_bits, output ready);
endinterface

// ===== hw/rtl/fpr_csr_if.sv =====
// Configuration write channel: register index and write data.
// Depends on fpr_pkg.
interface fpr_csr_if;
   import fpr_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/fpr_cell.sv =====
// One frame position of the FIFO chain: page id, R, M and occupied flag.
// On eviction it takes its upper neighbour's frame. Depends on fpr_pkg.
module fpr_cell #(
   parameter int PAGE_BITS = fpr_pkg::PAGE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  fpr_pkg::fpr_ctrl_type ctrl,
   input  logic [PAGE_BITS-1:0]  req_page,
   input  fpr_pkg::fpr_flags_type nb_flags,
   input  logic [PAGE_BITS-1:0]  nb_page,
   output fpr_pkg::fpr_flags_type flags,
   output logic [PAGE_BITS-1:0]  page,
   output fpr_pkg::fpr_flags_type flags_next,
   output logic                  match
);
   import fpr_pkg::*;

   fpr_flags_type        flags_ff, flags_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;

   // Tag compare against the request
   assign match = flags_ff.occ && (page_ff == req_page);

   // Next frame contents: load, shift from neighbour, or update in place
   always_comb begin
      flags_in = flags_ff;
      page_in  = page_ff;
      if (ctrl.step) begin
         if (ctrl.load) begin
            page_in        = req_page;
            flags_in.occ   = 1'b1;
            flags_in.r_bit = ~ctrl.wr;
            flags_in.m_bit = ctrl.wr;
         end else if (ctrl.shift) begin
            page_in        = nb_page;
            flags_in       = nb_flags;
            flags_in.r_bit = nb_flags.r_bit & ~ctrl.tick;
         end else begin
            flags_in.r_bit = (flags_ff.r_bit & ~ctrl.tick) | (match & ~ctrl.wr);
            flags_in.m_bit = flags_ff.m_bit | (match & ctrl.wr);
         end
      end
   end

   // Clear flags under reset; page id needs none
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
   end

   assign flags      = flags_ff;
   assign page       = page_ff;
   assign flags_next = flags_in;

endmodule

// ===== hw/rtl/fifo_page_replacement.sv =====
// FIFO page replacement with reference and modify bits: top level.
// Depends on fpr_pkg, fpr_req_if, fpr_rsp_if, fpr_csr_if and fpr_cell.
//
// Usage:
//  req_ch carries one page request per beat (page_id, access_time, is_write).
//  rsp_ch returns exactly one result beat per request: hit flag, evicted
//  page with write-back flag, clock-interrupt flag and time, and the R/M
//  bits of the resident frames in FIFO order, bit 0 oldest.
//  csr_ch writes tick_period (index 0) and frames_in_use (index 1); it is
//  always ready. Write only while no request is outstanding.
// Timing:
//  A request is processed in the cycle it is accepted; its result is
//  registered and shows on rsp_ch in the next cycle. One request per
//  cycle is sustained while rsp_ch.ready is high, as the cell chain
//  updates in the accepting cycle. While the receiver stalls the result
//  register holds and req_ch.ready drops, so at most one result waits.
// Reset:
//  Synchronous, active high. All frames empty, tick time zero,
//  tick_period 20, frames_in_use 5. No clearing pass is needed.
module fifo_page_replacement #(
   parameter int MAX_FRAMES = fpr_pkg::MAX_FRAMES_DEF,
   parameter int PAGE_BITS  = fpr_pkg::PAGE_BITS_DEF
) (
   input logic      clock,
   input logic      reset,
   fpr_req_if.sink  req_ch,
   fpr_rsp_if.source rsp_ch,
   fpr_csr_if.sink  csr_ch
);
   import fpr_pkg::*;

   localparam int CNT_W = $clog2(MAX_FRAMES + 1);
   localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   // Configuration registers
   logic [PERIOD_W-1:0] tick_period_ff, tick_period_in;
   logic [LIMIT_W-1:0]  frames_in_use_ff, frames_in_use_in;

   // Control state
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0] last_tick_ff, last_tick_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Result register
   logic                 hit_ff, hit_in;
   logic                 ev_valid_ff, ev_valid_in;
   logic [PAGE_BITS-1:0] ev_page_ff, ev_page_in;
   logic                 wb_ff, wb_in;
   logic                 tick_ff, tick_in;
   logic [BITS_W-1:0]    rbits_ff, rbits_in;
   logic [BITS_W-1:0]    mbits_ff, mbits_in;

   // Request decode
   logic              accept;
   logic              tick;
   logic [TIME_W:0]   tick_sum;
   logic              hit;
   logic              evict;
   logic [CMP_W-1:0]  limit;
   logic [CMP_W-1:0]  fiu_wide;
   logic [CNT_W-1:0]  ins_pos;

   // Cell chain
   fpr_ctrl_type         cell_ctrl  [MAX_FRAMES];
   fpr_flags_type        cell_flags [MAX_FRAMES];
   fpr_flags_type        cell_next  [MAX_FRAMES];
   fpr_flags_type        nb_flags   [MAX_FRAMES];
   logic [PAGE_BITS-1:0] cell_page  [MAX_FRAMES];
   logic [PAGE_BITS-1:0] nb_page    [MAX_FRAMES];
   logic [MAX_FRAMES-1:0] match_vec;
   logic [MAX_FRAMES-1:0] occ_vec;
   logic [MAX_FRAMES-1:0] r_next_vec;
   logic [MAX_FRAMES-1:0] m_next_vec;

   // Handshakes
   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = ~rsp_valid_ff | rsp_ch.ready;
   assign accept       = req_ch.valid & req_ch.ready;

   // Take configuration beats
   always_comb begin
      tick_period_in   = tick_period_ff;
      frames_in_use_in = frames_in_use_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_TICK_PERIOD:   tick_period_in   = csr_ch.data[PERIOD_W-1:0];
            CSR_FRAMES_IN_USE: frames_in_use_in = csr_ch.data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Clock interrupt check on 33 bits so an overflowing sum never fires
   assign tick_sum = {1'b0, last_tick_ff} + {{(TIME_W + 1 - PERIOD_W){1'b0}}, tick_period_ff};
   assign tick     = tick_sum <= {1'b0, req_ch.access_time};

   // Clamp the frame limit to 1..MAX_FRAMES
   assign fiu_wide = CMP_W'(frames_in_use_ff);
   always_comb begin
      if (fiu_wide == '0) begin
         limit = CMP_W'(1);
      end else if (fiu_wide > CMP_W'(MAX_FRAMES)) begin
         limit = CMP_W'(MAX_FRAMES);
      end else begin
         limit = fiu_wide;
      end
   end

   assign hit     = |match_vec;
   assign evict   = ~hit & (CMP_W'(count_ff) >= limit);
   assign ins_pos = evict ? (count_ff - CNT_W'(1)) : count_ff;

   // Build the chain of frame cells, oldest at index 0
   genvar gi;
   generate
      for (gi = 0; gi < MAX_FRAMES; gi++) begin : g_cell
         if (gi == MAX_FRAMES - 1) begin : g_last
            assign nb_flags[gi] = '0;
            assign nb_page[gi]  = '0;
         end else begin : g_mid
            assign nb_flags[gi] = cell_flags[gi+1];
            assign nb_page[gi]  = cell_page[gi+1];
         end

         assign cell_ctrl[gi].step  = accept;
         assign cell_ctrl[gi].tick  = tick;
         assign cell_ctrl[gi].shift = evict;
         assign cell_ctrl[gi].load  = ~hit & (ins_pos == CNT_W'(gi));
         assign cell_ctrl[gi].wr    = req_ch.is_write;

         fpr_cell #(
            .PAGE_BITS (PAGE_BITS)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (cell_ctrl[gi]),
            .req_page   (req_ch.page_id),
            .nb_flags   (nb_flags[gi]),
            .nb_page    (nb_page[gi]),
            .flags      (cell_flags[gi]),
            .page       (cell_page[gi]),
            .flags_next (cell_next[gi]),
            .match      (match_vec[gi])
         );

         assign occ_vec[gi]    = cell_flags[gi].occ;
         assign r_next_vec[gi] = cell_next[gi].r_bit;
         assign m_next_vec[gi] = cell_next[gi].m_bit;
      end

      // Fit the R/M snapshot to the output width
      for (gi = 0; gi < BITS_W; gi++) begin : g_bits
         if (gi < MAX_FRAMES) begin : g_have
            assign rbits_in[gi] = r_next_vec[gi];
            assign mbits_in[gi] = m_next_vec[gi];
         end else begin : g_pad
            assign rbits_in[gi] = 1'b0;
            assign mbits_in[gi] = 1'b0;
         end
      end
   endgenerate

   // Advance count and tick time on an accepted beat
   always_comb begin
      count_in     = count_ff;
      last_tick_in = last_tick_ff;
      if (accept) begin
         if (~hit & ~evict) begin
            count_in = count_ff + CNT_W'(1);
         end
         if (tick) begin
            last_tick_in = tick_sum[TIME_W-1:0];
         end
      end
   end

   // Result fields
   assign hit_in      = hit;
   assign ev_valid_in = evict;
   assign ev_page_in  = evict ? cell_page[0] : '0;
   assign wb_in       = evict & cell_flags[0].m_bit;
   assign tick_in     = tick;
   assign rsp_valid_in = accept | (rsp_valid_ff & ~rsp_ch.ready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_period_ff   <= TICK_PERIOD_RST;
         frames_in_use_ff <= FRAMES_IN_USE_RST;
         count_ff         <= '0;
         last_tick_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         tick_period_ff   <= tick_period_in;
         frames_in_use_ff <= frames_in_use_in;
         count_ff         <= count_in;
         last_tick_ff     <= last_tick_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Load the result register on an accepted beat, hold otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         hit_ff      <= hit_in;
         ev_valid_ff <= ev_valid_in;
         ev_page_ff  <= ev_page_in;
         wb_ff       <= wb_in;
         tick_ff     <= tick_in;
         rbits_ff    <= rbits_in;
         mbits_ff    <= mbits_in;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.hit             = hit_ff;
   assign rsp_ch.evicted_valid   = ev_valid_ff;
   assign rsp_ch.evicted_page    = ev_page_ff;
   assign rsp_ch.write_back      = wb_ff;
   assign rsp_ch.tick_taken      = tick_ff;
   assign rsp_ch.tick_time       = last_tick_ff;
   assign rsp_ch.referenced_bits = rbits_ff;
   assign rsp_ch.modified_bits   = mbits_ff;

`ifndef SYNTHESIS
   // Occupied cells form a contiguous run from the oldest, as long as the count
   a_occ_therm : assert property (@(posedge clock) disable iff (reset)
      ($countones(occ_vec) == int'(count_ff)) && ((occ_vec & (occ_vec + 1'b1)) == '0))
      else $error("occupied cells do not match resident count");

   // A page is resident in at most one frame
   a_one_match : assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("page matched in more than one frame");

   // An eviction leaves the resident count unchanged
   a_evict_count : assert property (@(posedge clock) disable iff (reset)
      accept && evict |=> count_ff == $past(count_ff))
      else $error("resident count moved on eviction");

   // Tick time never goes backwards
   a_tick_mono : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> last_tick_ff >= $past(last_tick_ff))
      else $error("tick time decreased");
`endif

endmodule

// ===== tb/fpr_tb_pkg.sv =====
`timescale 1ns / 100ps
// Result record and frame-table tracker for the FIFO page replacement bench.
// Depends on fpr_pkg.
package fpr_tb_pkg;
   import fpr_pkg::*;

   localparam int FRAMES = MAX_FRAMES_DEF;

   // One result beat as seen on the response channel
   typedef struct packed {
      logic                     hit;
      logic                     evicted_valid;
      logic [PAGE_BITS_DEF-1:0] evicted_page;
      logic                     write_back;
      logic                     tick_taken;
      logic [TIME_W-1:0]        tick_time;
      logic [BITS_W-1:0]        referenced_bits;
      logic [BITS_W-1:0]        modified_bits;
   } page_outcome_type;

   // Tracks the resident frames, their R/M flags and the tick time, and
   // holds the outcome each accepted request should produce.
   class page_replacement_tracker;
      bit [PERIOD_W-1:0]      tick_period;
      bit [LIMIT_W-1:0]       frames_in_use;
      bit [PAGE_BITS_DEF-1:0] frame_page [FRAMES];
      bit                     frame_ref  [FRAMES];
      bit                     frame_mod  [FRAMES];
      int                     oldest_slot;
      int                     resident_count;
      bit [TIME_W-1:0]        last_tick;
      page_outcome_type       expected_outcomes [$];
      int                     error_count;

      function new();
         tick_period    = TICK_PERIOD_RST;
         frames_in_use  = FRAMES_IN_USE_RST;
         oldest_slot    = 0;
         resident_count = 0;
         last_tick      = '0;
         error_count    = 0;
         foreach (frame_ref[i]) begin
            frame_ref[i] = 1'b0;
            frame_mod[i] = 1'b0;
         end
      endfunction

      // Unknown indexes are ignored by the block
      function void write_register(bit [CSR_IDX_W-1:0] idx, bit [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_TICK_PERIOD:   tick_period   = data[PERIOD_W-1:0];
            CSR_FRAMES_IN_USE: frames_in_use = data[LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      // Apply one request to the frame table and queue its outcome
      function void note_request(bit [PAGE_BITS_DEF-1:0] page, bit [TIME_W-1:0] stamp, bit wr);
         page_outcome_type o;
         bit               found;
         int               slot;
         int               limit;
         o     = '0;
         found = 1'b0;

         // Clock interrupt: at most one period per request, 33-bit compare
         if ({1'b0, last_tick} + {17'b0, tick_period} <= {1'b0, stamp}) begin
            last_tick    = last_tick + TIME_W'(tick_period);
            o.tick_taken = 1'b1;
            foreach (frame_ref[i]) frame_ref[i] = 1'b0;
         end

         // Only resident frames take part in the lookup
         for (int i = 0; i < resident_count; i++) begin
            slot = (oldest_slot + i) % FRAMES;
            if (frame_page[slot] == page) begin
               found = 1'b1;
               if (wr) frame_mod[slot] = 1'b1;
               else    frame_ref[slot] = 1'b1;
            end
         end

         if (found) begin
            o.hit = 1'b1;
         end else begin
            // Limit of zero acts as one, anything above the frame count saturates
            limit = (frames_in_use == 0) ? 1 :
                    (frames_in_use > FRAMES) ? FRAMES : int'(frames_in_use);
            if (resident_count >= limit) begin
               slot            = oldest_slot;
               o.evicted_valid = 1'b1;
               o.evicted_page  = frame_page[slot];
               o.write_back    = frame_mod[slot];
               frame_ref[slot] = 1'b0;
               frame_mod[slot] = 1'b0;
               oldest_slot     = (slot + 1) % FRAMES;
               resident_count--;
            end
            slot             = (oldest_slot + resident_count) % FRAMES;
            frame_page[slot] = page;
            frame_ref[slot]  = !wr;
            frame_mod[slot]  = wr;
            resident_count++;
         end

         o.tick_time = last_tick;
         for (int i = 0; i < resident_count && i < BITS_W; i++) begin
            slot                 = (oldest_slot + i) % FRAMES;
            o.referenced_bits[i] = frame_ref[slot];
            o.modified_bits[i]   = frame_mod[slot];
         end
         expected_outcomes.push_back(o);
      endfunction

      function void compare_field(string name, logic [TIME_W-1:0] exp_v,
                                  logic [TIME_W-1:0] act_v);
         if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            error_count++;
         end
      endfunction

      // Compare one result beat with the oldest outstanding outcome
      function void check_result(page_outcome_type got);
         page_outcome_type want;
         if (expected_outcomes.size() == 0) begin
            $error("result beat with no request outstanding");
            error_count++;
            return;
         end
         want = expected_outcomes.pop_front();
         compare_field("hit", TIME_W'(want.hit), TIME_W'(got.hit));
         compare_field("evicted_valid", TIME_W'(want.evicted_valid),
                       TIME_W'(got.evicted_valid));
         compare_field("evicted_page", TIME_W'(want.evicted_page),
                       TIME_W'(got.evicted_page));
         compare_field("write_back", TIME_W'(want.write_back), TIME_W'(got.write_back));
         compare_field("tick_taken", TIME_W'(want.tick_taken), TIME_W'(got.tick_taken));
         compare_field("tick_time", want.tick_time, got.tick_time);
         compare_field("referenced_bits", TIME_W'(want.referenced_bits),
                       TIME_W'(got.referenced_bits));
         compare_field("modified_bits", TIME_W'(want.modified_bits),
                       TIME_W'(got.modified_bits));
      endfunction

      function int outstanding();
         return expected_outcomes.size();
      endfunction
   endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Top-level bench for fifo_page_replacement: drives page requests and
// register writes, checks every result beat. Depends on fpr_pkg, the
// channel interfaces, fpr_tb_pkg and the RTL.
module tb_top;
   import fpr_pkg::*;
   import fpr_tb_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int POOL_SIZE   = 10;
   localparam int PHASES      = 9;
   localparam int DIRECTED    = 14;
   localparam int SWEEP_ITEMS = 30;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 4'd7;

   typedef enum {DRAIN_FREE, DRAIN_LIGHT, DRAIN_PATTERN, DRAIN_HEAVY} drain_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fpr_req_if req_if ();
   fpr_rsp_if rsp_if ();
   fpr_csr_if csr_if ();

   fifo_page_replacement dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   page_replacement_tracker tracker;

   int              cycle_count   = 0;
   int              burst_left    = 0;
   bit              full_rate     = 1'b0;
   bit              hold_request  = 1'b0;
   bit [TIME_W-1:0] now_ms        = '0;
   bit [15:0]       page_pool [POOL_SIZE];

   // Directed requests at the reset configuration (period 20, five frames)
   bit [15:0] dir_page [DIRECTED] = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h1234,
                                      16'h00AA, 16'h5555, 16'hAAAA, 16'hFFFF, 16'h8001,
                                      16'h1234, 16'h7FFE, 16'h00AA, 16'h4321};
   bit [31:0] dir_time [DIRECTED] = '{32'd0, 32'd5, 32'd10, 32'd19, 32'd20, 32'd25, 32'd39,
                                      32'd40, 32'd40, 32'd59, 32'd60, 32'd1000, 32'd1000,
                                      32'hFFFF_FFFF};
   bit        dir_wr   [DIRECTED] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
                                      1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

   // Random phases: register settings and request count
   bit [15:0] phase_period [PHASES] = '{16'd1, 16'd65535, 16'd0, 16'd7, 16'd3, 16'd100,
                                        16'd13, 16'd0, 16'd40};
   bit [15:0] phase_limit  [PHASES] = '{16'd8, 16'd1, 16'd3, 16'd15, 16'd2, 16'hFFF6,
                                        16'd0, 16'd8, 16'd4};
   int        phase_items  [PHASES] = '{100, 80, 80, 80, 100, 100, 90, 60, 80};

   // Clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Check every result beat taken by the receiver
   always @(posedge clock) begin
      page_outcome_type got;
      got.hit             = rsp_if.hit;
      got.evicted_valid   = rsp_if.evicted_valid;
      got.evicted_page    = rsp_if.evicted_page;
      got.write_back      = rsp_if.write_back;
      got.tick_taken      = rsp_if.tick_taken;
      got.tick_time       = rsp_if.tick_time;
      got.referenced_bits = rsp_if.referenced_bits;
      got.modified_bits   = rsp_if.modified_bits;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         tracker.check_result(got);
   end

   // Receiver: stall in changing patterns, with one long hold-off on request
   initial begin
      int             hold_left;
      int             mode_left;
      drain_mode_type mode;
      bit [15:0]      mask;
      bit [3:0]       pat_pos;
      hold_left = 0;
      mode_left = 0;
      mode      = DRAIN_FREE;
      mask      = '1;
      pat_pos   = '0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = 400;
            hold_request = 1'b0;
         end
         if (mode_left == 0) begin
            mode      = drain_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 120);
            mask      = 16'($urandom());
         end
         mode_left--;
         pat_pos++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (full_rate) begin
            rsp_if.ready <= ($urandom_range(0, 15) != 0);
         end else begin
            case (mode)
               DRAIN_FREE:    rsp_if.ready <= 1'b1;
               DRAIN_LIGHT:   rsp_if.ready <= ($urandom_range(0, 3) != 0);
               DRAIN_PATTERN: rsp_if.ready <= mask[pat_pos];
               default:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Offer one request beat; the sender works in bursts with gaps between
   task automatic offer_request(input bit [15:0] page, input bit [31:0] stamp, input bit wr);
      int gap;
      if (burst_left == 0) begin
         gap = full_rate ? $urandom_range(0, 1) : $urandom_range(0, 6);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         if (full_rate)
            burst_left = $urandom_range(50, 400);
         else if ($urandom_range(0, 3) == 0)
            burst_left = $urandom_range(20, 60);
         else
            burst_left = $urandom_range(1, 8);
      end
      req_if.valid       <= 1'b1;
      req_if.page_id     <= page;
      req_if.access_time <= stamp;
      req_if.is_write    <= wr;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      tracker.note_request(page, stamp, wr);
      burst_left--;
   endtask

   // Write one register; keep valid up when another write follows at once
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input bit [15:0] data,
                            input bit more);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      tracker.write_register(idx, data);
      if (!more) csr_if.valid <= 1'b0;
   endtask

   // Drop valid after the last beat of a phase and wait for every result
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   // Mostly nondecreasing time stamps, now and then an arbitrary one
   function automatic bit [31:0] next_stamp(int span);
      bit [32:0] sum;
      if ($urandom_range(0, 39) == 0) return $urandom();
      sum    = {1'b0, now_ms} + 33'($urandom_range(0, span));
      now_ms = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      return now_ms;
   endfunction

   // Mostly pages from a small working set so that hits are common
   function automatic bit [15:0] pick_page();
      if ($urandom_range(0, 4) != 0) return page_pool[$urandom_range(0, POOL_SIZE - 1)];
      return 16'($urandom());
   endfunction

   initial begin
      int span;
      tracker            = new();
      req_if.valid       = 1'b0;
      req_if.page_id     = '0;
      req_if.access_time = '0;
      req_if.is_write    = 1'b0;
      rsp_if.ready       = 1'b0;
      csr_if.valid       = 1'b0;
      csr_if.index       = CSR_TICK_PERIOD;
      csr_if.data        = '0;
      foreach (page_pool[i]) page_pool[i] = 16'($urandom());

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: fill, hits on both flags, dirty evictions, ticks
      for (int i = 0; i < DIRECTED; i++) offer_request(dir_page[i], dir_time[i], dir_wr[i]);
      drain_results();
      now_ms = 32'd1000;

      // Random phases across register settings
      for (int p = 0; p < PHASES; p++) begin
         write_csr(CSR_TICK_PERIOD, phase_period[p], 1'b1);
         write_csr(CSR_FRAMES_IN_USE, phase_limit[p], 1'b0);
         for (int k = 0; k < 3; k++)
            page_pool[$urandom_range(0, POOL_SIZE - 1)] = 16'($urandom());
         span = 2 * int'(phase_period[p]) + 3;
         if (p == 0) hold_request = 1'b1;
         for (int i = 0; i < phase_items[p]; i++)
            offer_request(pick_page(), next_stamp(span), 1'($urandom_range(0, 1)));
         drain_results();
      end

      // Back-to-back beats at the time ceiling with the widest period
      write_csr(CSR_UNUSED, 16'hBEEF, 1'b1);
      write_csr(CSR_TICK_PERIOD, 16'hFFFF, 1'b1);
      write_csr(CSR_FRAMES_IN_USE, 16'd8, 1'b0);
      full_rate = 1'b1;
      for (int i = 0; i < SWEEP_ITEMS; i++)
         offer_request(pick_page(), 32'hFFFF_FFFF, 1'($urandom_range(0, 1)));
      drain_results();
      full_rate = 1'b0;
      now_ms    = 32'hFFFF_FFFF;

      // Zero period fires on every request, then a period of one
      write_csr(CSR_TICK_PERIOD, 16'd0, 1'b1);
      write_csr(CSR_FRAMES_IN_USE, 16'd5, 1'b0);
      for (int i = 0; i < 20; i++)
         offer_request(pick_page(), next_stamp(3), 1'($urandom_range(0, 1)));
      drain_results();
      write_csr(CSR_TICK_PERIOD, 16'd1, 1'b0);
      for (int i = 0; i < 20; i++)
         offer_request(pick_page(), next_stamp(3), 1'($urandom_range(0, 1)));
      drain_results();

      // Let any stray beat show up before closing
      repeat (4) @(posedge clock);
      if (tracker.error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
